// File: src/pip_pkg.sv
// Shared types and constants for the point-in-polygon ray-cast block.
package pip_pkg;

   localparam int VERT_W = 31;   // coordinate width
   localparam int DIFF_W = 32;   // coordinate difference width
   localparam int PROD_W = 64;   // cross-product term width
   localparam int CNT_W  = 9;    // vertex_count register width
   localparam int IDX_W  = 8;    // vertex_index field width
   localparam int VERD_W = 2;    // verdict width

   localparam logic FUNC_WRITE = 1'b0;
   localparam logic FUNC_QUERY = 1'b1;

   localparam logic [VERD_W-1:0] VERDICT_OUTSIDE  = 2'd0;
   localparam logic [VERD_W-1:0] VERDICT_INSIDE   = 2'd1;
   localparam logic [VERD_W-1:0] VERDICT_BOUNDARY = 2'd2;

   typedef struct packed {
      logic signed [VERT_W-1:0] y;
      logic signed [VERT_W-1:0] x;
   } vertex_type;

   // tags a vertex read as it comes back from the store
   typedef struct packed {
      logic vld;
      logic first;
      logic last;
   } edge_ctl_type;

   typedef struct packed {
      logic              done;
      logic [VERD_W-1:0] verdict;
   } edge_res_type;

endpackage

// File: src/point_in_polygon_ray_cast_top.sv
// Top level of the point-in-polygon ray-cast block: sequencer, store and edge pipeline.
//
// Usage. Requests arrive on the req_ stream; req_tuser selects the kind:
// a write request stores one vertex (x, y) in slot vertex_index and gives no
// response; a query request gives a point and yields one verdict on the rsp_
// stream (0 outside, 1 inside, 2 on the boundary). csr_wen/csr_wdata set the
// number of vertices in use; write it only while the block is idle.
// Query walk. A query walks the vertex store one read per cycle (vertex 0
// up to the last, then vertex 0 again for the closing edge), feeding a
// three-stage edge pipeline; the single read port of the store sets the
// rate of the walk.
// One request is worked at a time: req_tready is high only while idle.
// Back-pressure. The verdict sits in an output register, so the next request
// is taken while a verdict waits; a query that finishes while the register
// is still full holds until rsp_tready drains it.
// Reset. Synchronous and active high: clears the sequencer, the pipeline
// flags and the output valid, and sets vertex_count to 3. The store is not
// cleared; every slot in use must be written before it is queried.
module point_in_polygon_ray_cast_top #(
   parameter int MAX_VERTICES = 256
) (
   input  logic        clock,
   input  logic        reset,
   // request stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [71:0] req_tdata,   // [7:0] vertex_index, [38:8] x, [69:39] y, [71:70] zero
   input  logic        req_tuser,   // [0] func
   // response stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [1:0] verdict, [7:2] zero
   // vertex count register
   input  logic        csr_wen,
   input  logic [8:0]  csr_wdata
);

   localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
   localparam int CW = $clog2(MAX_VERTICES + 1);
   localparam int NW = (CW > pip_pkg::CNT_W) ? CW : pip_pkg::CNT_W;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_WALK = 2'd1;
   localparam logic [1:0] ST_WAIT = 2'd2;
   localparam logic [1:0] ST_SEND = 2'd3;

   logic [1:0]                 state_ff, state_in;
   logic [pip_pkg::CNT_W-1:0]  vertex_count_ff;
   logic [CW-1:0]              n_ff, cnt_ff, cnt_in;
   logic [CW-1:0]              n_eff;
   logic [NW-1:0]              count_wide;
   pip_pkg::vertex_type        pt_ff;
   pip_pkg::vertex_type        req_vtx;
   pip_pkg::edge_ctl_type      rd_ctl, rd_ctl_ff;
   pip_pkg::edge_res_type      res;
   pip_pkg::vertex_type        rd_data;
   logic [pip_pkg::VERD_W-1:0] verdict_ff;
   logic                       rsp_tvalid_ff, rsp_tvalid_in;
   logic                       req_accept, is_query, start, wr_en, load_rsp;
   logic [AW-1:0]              wr_addr, rd_addr;
   logic [31:0]                idx_wide;

   // unpack the request
   assign req_vtx.x  = req_tdata[38:8];
   assign req_vtx.y  = req_tdata[69:39];
   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign is_query   = (req_tuser == pip_pkg::FUNC_QUERY);
   assign start      = req_accept && is_query;

   // drop writes to slots beyond the store
   assign idx_wide = {{(32 - pip_pkg::IDX_W){1'b0}}, req_tdata[7:0]};
   assign wr_en    = req_accept && !is_query && (idx_wide < 32'(MAX_VERTICES));
   assign wr_addr  = idx_wide[AW-1:0];

   // saturate the vertex count to the store depth
   always_comb begin
      count_wide = NW'(vertex_count_ff);
      if (count_wide > NW'(MAX_VERTICES)) begin
         count_wide = NW'(MAX_VERTICES);
      end
      n_eff = count_wide[CW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vertex_count_ff <= pip_pkg::CNT_W'(3);
      end else if (csr_wen) begin
         vertex_count_ff <= csr_wdata;
      end
   end

   // walk reads: slots 0..n-1, then slot 0 again to close the polygon
   always_comb begin
      rd_ctl.vld   = (state_ff == ST_WALK);
      rd_ctl.first = (cnt_ff == '0);
      rd_ctl.last  = (cnt_ff == n_ff);
      rd_addr      = rd_ctl.last ? '0 : cnt_ff[AW-1:0];
   end

   assign load_rsp = (state_ff == ST_SEND) && (!rsp_tvalid_ff || rsp_tready);

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      unique case (state_ff)
         ST_IDLE: begin
            cnt_in = '0;
            if (start) begin
               state_in = (n_eff == '0) ? ST_SEND : ST_WALK;
            end
         end
         ST_WALK: begin
            cnt_in = cnt_ff + CW'(1);
            if (rd_ctl.last) begin
               state_in = ST_WAIT;
            end
         end
         ST_WAIT: begin
            if (res.done) begin
               state_in = ST_SEND;
            end
         end
         ST_SEND: begin
            if (load_rsp) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // output register: a fresh load wins over a drain
   always_comb begin
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      if (load_rsp) begin
         rsp_tvalid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         cnt_ff        <= '0;
         n_ff          <= '0;
         rd_ctl_ff     <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         rd_ctl_ff     <= rd_ctl;
         rsp_tvalid_ff <= rsp_tvalid_in;
         if (start) begin
            n_ff <= n_eff;
         end
      end
   end

   // hold the query point and the verdict
   always_ff @(posedge clock) begin
      if (start) begin
         pt_ff <= req_vtx;
      end
      if (load_rsp) begin
         verdict_ff <= res.verdict;
      end
   end

   pip_vertex_ram #(
      .DEPTH (MAX_VERTICES),
      .AW    (AW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_vtx),
      .rd_en   (rd_ctl.vld),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   pip_edge_unit u_edge (
      .clock (clock),
      .reset (reset),
      .start (start),
      .ctl   (rd_ctl_ff),
      .vtx   (rd_data),
      .pt    (pt_ff),
      .res   (res)
   );

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {6'd0, verdict_ff};

endmodule

// File: src/pip_vertex_ram.sv
// Vertex store: one write port, one registered read port.
module pip_vertex_ram #(
   parameter int DEPTH = 256,
   parameter int AW    = 8
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [AW-1:0]        wr_addr,
   input  pip_pkg::vertex_type  wr_data,
   input  logic                 rd_en,
   input  logic [AW-1:0]        rd_addr,
   output pip_pkg::vertex_type  rd_data
);

   pip_pkg::vertex_type vertex_mem_ff [DEPTH];
   pip_pkg::vertex_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         vertex_mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= vertex_mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: src/pip_edge_unit.sv
// Edge pipeline: differences, cross products, then boundary and crossing tally.
module pip_edge_unit (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  pip_pkg::edge_ctl_type  ctl,
   input  pip_pkg::vertex_type    vtx,
   input  pip_pkg::vertex_type    pt,
   output pip_pkg::edge_res_type  res
);

   localparam int DW = pip_pkg::DIFF_W;
   localparam int PW = pip_pkg::PROD_W;

   pip_pkg::vertex_type prev_ff;

   // stage 1
   logic                 s1_vld_ff, s1_vld_in;
   logic                 s1_last_ff;
   logic signed [DW-1:0] s1_dx_ff, s1_dy_ff, s1_dpx_ff, s1_dpy_ff;
   logic                 s1_box_ff, s1_strad_ff, s1_up_ff;
   logic signed [DW-1:0] dx_in, dy_in, dpx_in, dpy_in;
   logic                 box_in, strad_in, up_in;

   // stage 2
   logic                 s2_vld_ff, s2_last_ff;
   logic signed [PW-1:0] s2_lhs_ff, s2_rhs_ff;
   logic                 s2_box_ff, s2_strad_ff, s2_up_ff;

   // tally
   logic boundary_ff, parity_ff, done_ff;
   logic on_edge, crosses;

   pip_pkg::vertex_type a;
   assign a = prev_ff;

   always_comb begin
      dx_in  = {vtx.x[pip_pkg::VERT_W-1], vtx.x} - {a.x[pip_pkg::VERT_W-1], a.x};
      dy_in  = {vtx.y[pip_pkg::VERT_W-1], vtx.y} - {a.y[pip_pkg::VERT_W-1], a.y};
      dpx_in = {pt.x[pip_pkg::VERT_W-1], pt.x} - {a.x[pip_pkg::VERT_W-1], a.x};
      dpy_in = {pt.y[pip_pkg::VERT_W-1], pt.y} - {a.y[pip_pkg::VERT_W-1], a.y};
      box_in = ((pt.x >= a.x && pt.x <= vtx.x) || (pt.x >= vtx.x && pt.x <= a.x)) &&
               ((pt.y >= a.y && pt.y <= vtx.y) || (pt.y >= vtx.y && pt.y <= a.y));
      strad_in  = (a.y > pt.y) != (vtx.y > pt.y);
      up_in     = vtx.y > a.y;
      s1_vld_in = ctl.vld && !ctl.first;
   end

   always_ff @(posedge clock) begin
      if (ctl.vld) begin
         prev_ff <= vtx;
      end
      s1_dx_ff    <= dx_in;
      s1_dy_ff    <= dy_in;
      s1_dpx_ff   <= dpx_in;
      s1_dpy_ff   <= dpy_in;
      s1_box_ff   <= box_in;
      s1_strad_ff <= strad_in;
      s1_up_ff    <= up_in;
      s2_lhs_ff   <= PW'(s1_dx_ff) * PW'(s1_dpy_ff);
      s2_rhs_ff   <= PW'(s1_dy_ff) * PW'(s1_dpx_ff);
      s2_box_ff   <= s1_box_ff;
      s2_strad_ff <= s1_strad_ff;
      s2_up_ff    <= s1_up_ff;
   end

   always_comb begin
      on_edge = (s2_lhs_ff == s2_rhs_ff) && s2_box_ff;
      crosses = s2_strad_ff && (s2_up_ff ? (s2_lhs_ff > s2_rhs_ff)
                                         : (s2_lhs_ff < s2_rhs_ff));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff   <= 1'b0;
         s1_last_ff  <= 1'b0;
         s2_vld_ff   <= 1'b0;
         s2_last_ff  <= 1'b0;
         boundary_ff <= 1'b0;
         parity_ff   <= 1'b0;
         done_ff     <= 1'b0;
      end else begin
         s1_vld_ff  <= s1_vld_in;
         s1_last_ff <= s1_vld_in && ctl.last;
         s2_vld_ff  <= s1_vld_ff;
         s2_last_ff <= s1_vld_ff && s1_last_ff;
         done_ff    <= s2_vld_ff && s2_last_ff;
         if (start) begin
            boundary_ff <= 1'b0;
            parity_ff   <= 1'b0;
         end else if (s2_vld_ff) begin
            boundary_ff <= boundary_ff | on_edge;
            parity_ff   <= parity_ff ^ (crosses && !on_edge);
         end
      end
   end

   always_comb begin
      res.done = done_ff;
      priority if (boundary_ff) begin
         res.verdict = pip_pkg::VERDICT_BOUNDARY;
      end else if (parity_ff) begin
         res.verdict = pip_pkg::VERDICT_INSIDE;
      end else begin
         res.verdict = pip_pkg::VERDICT_OUTSIDE;
      end
   end

endmodule
